>>> design/hkm_pkg.sv
// shared types, codes and helpers for the k-way heap merger
package hkm_pkg;

  // item actions carried on the input tuser
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_NEXT  = 2'd2;
  localparam logic [1:0] ACT_EXH   = 2'd3;

  localparam int ValueW = 32;
  localparam int RunW   = 4;

  // one heap entry as held in the entry ram
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [RunW-1:0]   run;
    logic              exh;
  } entry_t;

  localparam int EntryW = ValueW + RunW + 1;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // latch the incoming item
    logic load_wr;     // append a run head
    logic start;       // enter merging, set up the build counter
    logic sift_root;   // begin a sift from the root for the latched item
    logic build_next;  // begin the next build sift
    logic rd_pos;      // read port a at the sift position
    logic take_cur;    // capture the entry being sifted
    logic cur_mod;     // apply the latched item to the captured root
    logic cmp_step;    // compare with children and write one level
    logic emit;        // load the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic merging;
    logic can_load;
    logic all_done;
    logic k_zero;
    logic sift_end;
    logic out_free;
  } sts_t;

  // entry a orders strictly before entry b; exhausted entries sort last
  function automatic logic entry_less(entry_t a, entry_t b);
    return !a.exh && (b.exh || ($signed(a.value) < $signed(b.value)));
  endfunction

endpackage

>>> design/hkm_ram.sv
// generic ram, one write port and two registered read ports
module hkm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> design/hkm_ctrl.sv
// controller state machine of the k-way heap merger
module hkm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [1:0]    s_axis_tuser,   // action
  input  hkm_pkg::sts_t sts_i,
  output hkm_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BUILD = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_FIRST = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       build_q, build_d;
  logic       accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next state and commands
  always_comb begin
    state_d = state_q;
    build_d = build_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            hkm_pkg::ACT_LOAD: begin
              cmd_o.load_wr = !sts_i.merging && sts_i.can_load;
            end
            hkm_pkg::ACT_START: begin
              if (!sts_i.merging) begin
                cmd_o.start = 1'b1;
                build_d     = 1'b1;
                state_d     = ST_BUILD;
              end
            end
            default: begin
              if (sts_i.merging) begin
                if (sts_i.all_done) begin
                  state_d = ST_EMIT;
                end else begin
                  cmd_o.sift_root = 1'b1;
                  build_d         = 1'b0;
                  state_d         = ST_FETCH;
                end
              end
            end
          endcase
        end
      end
      ST_BUILD: begin
        if (sts_i.k_zero) begin
          build_d = 1'b0;
          state_d = ST_EMIT;
        end else begin
          cmd_o.build_next = 1'b1;
          state_d          = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = ST_FIRST;
      end
      ST_FIRST: begin
        cmd_o.take_cur = 1'b1;
        cmd_o.cur_mod  = !build_q;
        state_d        = ST_CMP;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.sift_end) begin
          state_d = build_q ? ST_BUILD : ST_EMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      build_q <= build_d;
    end
  end

  // a compare step always follows a read of the children
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRST || state_q == ST_READ) |=> (state_q == ST_CMP))
    else $error("compare step not after child read");

  // sifting never runs while an item may be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cmp_step |-> !s_axis_tready)
    else $error("sift overlaps item acceptance");

  // a build ends in an emit once the counter runs out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUILD && sts_i.k_zero) |=> (state_q == ST_EMIT))
    else $error("build did not end in emit");

endmodule

>>> design/hkm_dpath.sv
// datapath of the k-way heap merger: entry ram, counters, sift unit, output register
module hkm_dpath #(
  parameter int MaxRuns = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hkm_pkg::cmd_t cmd_i,
  output hkm_pkg::sts_t sts_o,
  input  logic [4:0]    run_count_i,
  input  logic [1:0]    s_axis_tuser,   // action
  input  logic [31:0]   s_axis_tdata,   // value
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [39:0]   m_axis_tdata,   // min_value, source_run, zero pad
  output logic          m_axis_tuser    // all_done
);

  localparam int IW = $clog2(MaxRuns);
  localparam int CW = $clog2(MaxRuns + 1);
  localparam int XW = IW + 2;
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int EntryRamW = hkm_pkg::EntryW;

  logic [CW-1:0] loaded_q, exh_q, k_q;
  logic          merging_q;
  logic [IW-1:0] pos_q;
  logic [1:0]    act_q;
  logic [31:0]   val_q;
  hkm_pkg::entry_t cur_q, root_q;
  logic          m_valid_q;
  logic [39:0]   m_data_q;
  logic          m_done_q;

  logic [XW-1:0] left_x, right_x;
  logic          left_ok, right_ok;
  logic [EntryRamW-1:0] rd_a, rd_b;
  hkm_pkg::entry_t ent_l, ent_r, best, new_ent, taken;
  logic [1:0]    sel;
  logic          we;
  logic [IW-1:0] waddr;
  hkm_pkg::entry_t wdata;
  logic [CW+3:0] run_ext;
  logic          all_done;

  // child positions and bounds
  assign left_x   = {1'b0, pos_q, 1'b1};
  assign right_x  = left_x + XW'(1);
  assign left_ok  = left_x < XW'(loaded_q);
  assign right_ok = right_x < XW'(loaded_q);

  assign ent_l = hkm_pkg::entry_t'(rd_a);
  assign ent_r = hkm_pkg::entry_t'(rd_b);

  // pick the smallest of the sifted entry and its children, ties keep the parent
  always_comb begin
    best = cur_q;
    sel  = 2'd0;
    if (left_ok && hkm_pkg::entry_less(ent_l, cur_q)) begin
      best = ent_l;
      sel  = 2'd1;
    end
    if (right_ok && hkm_pkg::entry_less(ent_r, best)) begin
      best = ent_r;
      sel  = 2'd2;
    end
  end

  // new run head as appended by a load
  assign run_ext = {4'b0, loaded_q};
  always_comb begin
    new_ent.value = s_axis_tdata;
    new_ent.run   = run_ext[3:0];
    new_ent.exh   = 1'b0;
  end

  // entry read at the sift position, with the latched item applied for a root sift
  always_comb begin
    taken = ent_l;
    if (cmd_i.cur_mod) begin
      if (act_q == hkm_pkg::ACT_NEXT) begin
        taken.value = val_q;
      end else begin
        taken.exh = 1'b1;
      end
    end
  end

  // ram write port
  assign we    = cmd_i.load_wr || cmd_i.cmp_step;
  assign waddr = cmd_i.load_wr ? loaded_q[IW-1:0] : pos_q;
  assign wdata = cmd_i.load_wr ? new_ent : best;

  hkm_ram #(
    .Width (EntryRamW),
    .Depth (MaxRuns)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.rd_pos ? pos_q : left_x[IW-1:0]),
    .raddr_b_i (right_x[IW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign all_done = exh_q >= loaded_q;

  // status
  always_comb begin
    sts_o.merging  = merging_q;
    sts_o.can_load = (LW'(loaded_q) < LW'(run_count_i)) && (loaded_q < CW'(MaxRuns));
    sts_o.all_done = all_done;
    sts_o.k_zero   = (k_q == '0);
    sts_o.sift_end = (sel == 2'd0);
    sts_o.out_free = !m_valid_q || m_axis_tready;
  end

  // counters, phase and sift position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      exh_q     <= '0;
      k_q       <= '0;
      merging_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (cmd_i.load_wr) begin
        loaded_q <= loaded_q + CW'(1);
      end
      if (cmd_i.start) begin
        merging_q <= 1'b1;
        exh_q     <= '0;
        k_q       <= loaded_q >> 1;
      end
      if (cmd_i.sift_root) begin
        pos_q <= '0;
        if (s_axis_tuser == hkm_pkg::ACT_EXH) begin
          exh_q <= exh_q + CW'(1);
        end
      end
      if (cmd_i.build_next) begin
        k_q   <= k_q - CW'(1);
        pos_q <= IW'(k_q - CW'(1));
      end
      if (cmd_i.cmp_step && sel != 2'd0) begin
        pos_q <= (sel == 2'd1) ? left_x[IW-1:0] : right_x[IW-1:0];
      end
    end
  end

  // latched item, sifted entry and root copy
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= s_axis_tuser;
      val_q <= s_axis_tdata;
    end
    if (cmd_i.take_cur) begin
      cur_q <= taken;
    end
    if (we && waddr == '0) begin
      root_q <= wdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_done_q <= all_done;
      if (all_done) begin
        m_data_q <= '0;
      end else begin
        m_data_q <= {4'b0, root_q.run, root_q.value};
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_done_q;

  // exhausted runs never outnumber loaded ones
  assert property (@(posedge clk_i) disable iff (!rst_ni) exh_q <= loaded_q)
    else $error("exhausted count above loaded count");

  // a sift that moves goes strictly down the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmp_step && sel != 2'd0) |=> (pos_q > $past(pos_q)))
    else $error("sift did not move down");

  // the heap never holds more entries than its storage
  assert property (@(posedge clk_i) disable iff (!rst_ni) loaded_q <= CW'(MaxRuns))
    else $error("loaded count beyond storage");

endmodule

>>> design/heap_k_way_merger.sv
// top level of the k-way heap merger: register port, controller and datapath
//
// Merges up to MaxRuns sorted runs through a binary min-heap held in a small ram.
// Load items (action 0) take one run head each and number runs in load order, up to
// run_count; start (action 1) builds the heap and gives the minimum; next (action 2)
// and exhausted (action 3) replace or retire the head of the run just given, and the
// new minimum follows. With every run exhausted the result carries all_done and zero
// fields. Each sift level is a child read, then a compare and write, since the ram has a
// single write port and a registered read. A start sifts each of the loaded_count/2
// inner nodes down in turn, from the last to the root. One item is worked on at a time;
// a finished result waits in an output register while the next item is taken.
module heap_k_way_merger #(
  parameter int MaxRuns = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [1:0]  s_axis_tuser,   // action
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // min_value [31:0], source_run [35:32], zero pad
  output logic        m_axis_tuser,   // all_done
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [0:0] REG_RUN_COUNT = 1'b0;

  logic [4:0]    run_count_q;
  hkm_pkg::cmd_t cmd;
  hkm_pkg::sts_t sts;

  // run_count register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= 5'd1;
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_RUN_COUNT) begin
      run_count_q <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2:2] == REG_RUN_COUNT) ? {27'b0, run_count_q} : 32'b0;

  hkm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  hkm_dpath #(
    .MaxRuns (MaxRuns)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .run_count_i   (run_count_q),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
